>>> rtl/core/pas_pkg.sv
// Shared widths, input kind codes and inter-module structs for the priority aging scheduler.
`timescale 1ns / 1ps

package pas_pkg;

  localparam int KIND_W = 2;
  localparam int SLOT_W = 4;
  localparam int TIME_W = 16;
  localparam int PRI_W  = 8;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  localparam logic [TIME_W-1:0] TIME_MAX     = 16'hFFFF;
  localparam logic [TIME_W-1:0] AGING_RESET  = 16'd5;
  localparam logic [PRI_W-1:0]  PRI_FLOOR    = 8'd1;

  // Saturating count of slots with work left: none, one, or more than one.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_MANY = 2'd2;

  // Commands broadcast from the top level to every cell.
  typedef struct packed {
    logic              clear;
    logic              load;
    logic              tick;
    logic              commit;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] sel;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRI_W-1:0]  prio;
  } pas_ctrl_t;

  // Running best candidate handed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [PRI_W-1:0]  pri;
    logic              last;
    logic [1:0]        pend;
  } pas_cand_t;

endpackage

>>> rtl/core/pas_channels.sv
// Valid/ready channel interfaces for scheduler input items and result items.
`timescale 1ns / 1ps

interface pas_in_if import pas_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] burst_time;
  logic [PRI_W-1:0]  base_priority;

  modport source (output valid, kind, slot, arrival_time, burst_time, base_priority,
                  input ready);
  modport sink (input valid, kind, slot, arrival_time, burst_time, base_priority,
                output ready);
endinterface

interface pas_out_if import pas_pkg::*;;
  logic              valid;
  logic              ready;
  logic              ran;
  logic [SLOT_W-1:0] run_slot;
  logic [TIME_W-1:0] tick_time;
  logic              slot_finished;
  logic              all_done;

  modport source (output valid, ran, run_slot, tick_time, slot_finished, all_done,
                  input ready);
  modport sink (input valid, ran, run_slot, tick_time, slot_finished, all_done,
                output ready);
endinterface

>>> rtl/core/pas_cell.sv
// One process slot of the scheduler chain: slot state, aging and one stage of the minimum search.
`timescale 1ns / 1ps

module pas_cell import pas_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  pas_ctrl_t ctrl,
  input  pas_cand_t cand_in,
  output pas_cand_t cand_out
);

  logic              loaded;
  logic              ready;
  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] remaining;
  logic [PRI_W-1:0]  priority_val;
  logic [TIME_W-1:0] last_aging;

  logic              hit_load;
  logic              mine;
  logic              arrive;
  logic              ready_tick;
  logic              age;
  logic [TIME_W-1:0] waited;
  logic [PRI_W-1:0]  pri_aged;
  logic              busy;
  logic              take;
  pas_cand_t         cand_next;

  always_comb begin
    hit_load   = ctrl.load && (int'(ctrl.slot) == INDEX);
    mine       = ctrl.commit && (int'(ctrl.sel) == INDEX);
    arrive     = loaded && !ready && (remaining != '0) && (arrival == ctrl.now);
    ready_tick = ready || arrive;
    waited     = ctrl.now - last_aging;
    age        = ready_tick && (waited >= ctrl.interval);
    pri_aged   = (priority_val > PRI_FLOOR) ? priority_val - PRI_FLOOR : PRI_FLOOR;
    busy       = loaded && (remaining != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      ready  <= 1'b0;
    end else if (ctrl.clear) begin
      loaded <= 1'b0;
      ready  <= 1'b0;
    end else if (hit_load) begin
      loaded <= 1'b1;
      ready  <= 1'b0;
    end else if (ctrl.tick) begin
      ready <= ready_tick;
    end else if (mine && (remaining == TIME_W'(1))) begin
      ready <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_load) begin
      arrival      <= ctrl.arrival;
      remaining    <= ctrl.burst;
      priority_val <= ctrl.prio;
      last_aging   <= ctrl.arrival;
    end else if (ctrl.tick && age) begin
      priority_val <= pri_aged;
      last_aging   <= ctrl.now;
    end else if (mine) begin
      remaining <= remaining - TIME_W'(1);
    end
  end

  // Strict compare keeps the earlier, lower-indexed slot on a tie.
  always_comb begin
    take      = ready && (!cand_in.found || (priority_val < cand_in.pri));
    cand_next = cand_in;
    if (take) begin
      cand_next.found = 1'b1;
      cand_next.idx   = SLOT_W'(INDEX);
      cand_next.pri   = priority_val;
      cand_next.last  = (remaining == TIME_W'(1));
    end
    if (busy) begin
      cand_next.pend = (cand_in.pend == PEND_NONE) ? PEND_ONE : PEND_MANY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
    end else begin
      cand_out <= cand_next;
    end
  end

endmodule

>>> rtl/core/priority_aging_scheduler_core.sv
// Top level of the tick-driven preemptive priority scheduler with aging.
`timescale 1ns / 1ps

// The scheduler keeps NUM_SLOTS process slots in a row of cells, one slot per cell. A clear
// or load input transfer leaves the input open and produces no result. A tick transfer holds
// off the next input transfer until its result is committed: in the accept cycle
// every cell marks arrivals and ages its priority in parallel, then the running best
// candidate walks down the cell chain, one registered cell per cycle, through all NUM_SLOTS
// cells, and in a final commit cycle the winning slot is charged one unit and the result
// is written into the output register. The commit waits only if a previous result is still
// held and not being taken in that cycle; clear and load transfers are accepted while a
// result waits. Ties in priority go to the lowest slot index, priority values are floored
// at 1 by aging, time saturates at 65535, and a slot index at or above NUM_SLOTS is ignored
// on load. The aging interval register (reset 5) is written through cfg_we/cfg_wdata and
// should only change while the block is idle.
module priority_aging_scheduler_core import pas_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  pas_in_if.sink            in_ch,
  pas_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(NUM_SLOTS);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SCAN   = 2'd1;
  localparam logic [1:0] PH_COMMIT = 2'd2;

  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [CNT_W-1:0]  scan_cnt;
  logic [TIME_W-1:0] aging_interval;
  logic [TIME_W-1:0] current_time;

  logic              in_fire;
  logic              out_free;
  logic              commit;
  pas_ctrl_t         ctrl;
  pas_cand_t         chain [NUM_SLOTS+1];
  pas_cand_t         best;
  logic              done;

  // Register the aging interval on every write strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      aging_interval <= AGING_RESET;
    end else if (cfg_we) begin
      aging_interval <= cfg_wdata;
    end
  end

  // Input is taken only between ticks; the output register decouples the result side.
  assign in_ch.ready = (phase == PH_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign commit      = (phase == PH_COMMIT) && out_free;

  // Only a tick that found a winner charges a slot; an idle tick leaves every slot alone.
  always_comb begin
    ctrl.clear    = in_fire && (in_ch.kind == KIND_CLEAR);
    ctrl.load     = in_fire && (in_ch.kind == KIND_LOAD);
    ctrl.tick     = in_fire && (in_ch.kind == KIND_TICK);
    ctrl.commit   = commit && best.found;
    ctrl.slot     = in_ch.slot;
    ctrl.sel      = best.idx;
    ctrl.now      = current_time;
    ctrl.interval = aging_interval;
    ctrl.arrival  = in_ch.arrival_time;
    ctrl.burst    = in_ch.burst_time;
    ctrl.prio     = in_ch.base_priority;
  end

  // The head of the chain starts with no candidate and no pending slots.
  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    pas_cell #(
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1])
    );
  end

  assign best = chain[NUM_SLOTS];

  // The winner is always ready and still has work, so it is counted in the pending count.
  // Everything is done once no other slot has work and the winner uses its last unit.
  assign done = best.found ? ((best.pend == PEND_ONE) && best.last)
                           : (best.pend == PEND_NONE);

  // The tail of the chain is valid after one registered step per cell.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (ctrl.tick) begin
          phase_next = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (scan_cnt == CNT_W'(NUM_SLOTS - 1)) begin
          phase_next = PH_COMMIT;
        end
      end
      PH_COMMIT: begin
        if (commit) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      scan_cnt <= '0;
    end else begin
      phase <= phase_next;
      if (phase == PH_SCAN) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  // Time advances once per tick at commit and stops at its maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
    end else if (ctrl.clear) begin
      current_time <= '0;
    end else if (commit && (current_time != TIME_MAX)) begin
      current_time <= current_time + TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (commit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ch.ran           <= best.found;
      out_ch.run_slot      <= best.found ? best.idx : '0;
      out_ch.tick_time     <= current_time;
      out_ch.slot_finished <= best.found && best.last;
      out_ch.all_done      <= done;
    end
  end

endmodule

>>> rtl/core/pas_checker.sv
// Port-level assertions for the scheduler core and the bind that attaches them.
`timescale 1ns / 1ps

module pas_checker import pas_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [KIND_W-1:0] in_kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic              ran,
  input logic [SLOT_W-1:0] run_slot,
  input logic              slot_finished
);

  // A tick occupies the block, so input is refused in the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_kind == KIND_TICK)) |=> !in_ready)
    else $error("input accepted right after a tick transfer");

  // Clear, load and unused kinds finish at once and leave the block open.
  a_short_items: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_kind != KIND_TICK)) |=> in_ready)
    else $error("block busy after a non-tick transfer");

  // An idle tick reports slot zero and no finish.
  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ran) |-> ((run_slot == '0) && !slot_finished))
    else $error("idle result carries a slot or a finish");

  // A held result stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(run_slot) && $stable(ran)))
    else $error("stalled result changed or dropped");

endmodule

bind priority_aging_scheduler_core pas_checker u_pas_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_kind       (in_ch.kind),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .ran           (out_ch.ran),
  .run_slot      (out_ch.run_slot),
  .slot_finished (out_ch.slot_finished)
);

>>> verif/tb_priority_aging_scheduler_core.sv
// Self-checking testbench for the priority aging scheduler core.
`timescale 1ns / 1ps

// The bench drives input transfers through the in_ch channel and collects
// result transfers from out_ch. A small checker class keeps a cycle-free model
// of the scheduler state: every accepted input transfer is applied to it, and
// every tick produces one predicted report that waits in a queue. Each result
// transfer is compared field by field with the oldest predicted report.
//
// The run has three parts. A short directed sequence touches every input kind,
// the field extremes and the corner cases of the scheduler. A short tick run
// then checks aging on every tick with interval zero. After that,
// random phases each set a new aging interval and feed batches of well-formed
// work: an optional clear, a few loads that arrive soon, and enough ticks to
// finish them, salted with mid-run loads and some noise. The last phase runs
// with no idling on either side.
module tb_priority_aging_scheduler_core import pas_pkg::*; ();

  localparam int SLOT_COUNT    = 16;
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  // Quiet cycles after the last result before a register write; covers a
  // load or clear that may still be in flight behind the final tick.
  localparam int SETTLE_CYCLES = 2 * (SLOT_COUNT + 2) + 4;
  // Cycles with no transfer on either channel before the run is abandoned.
  localparam int STALL_LIMIT   = 1000;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 236;
  localparam int ZERO_TICKS    = 40;

  // Kind 3 has no meaning for the block; it must be dropped without a result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRI_W-1:0]  prio;
  } sched_item_t;

  typedef struct packed {
    logic              ran;
    logic [SLOT_W-1:0] run_slot;
    logic [TIME_W-1:0] tick_time;
    logic              slot_finished;
    logic              all_done;
  } tick_report_t;

  // Scheduler state copy plus the queue of tick reports still owed by the block.
  class schedule_checker #(int SLOTS = 16);
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] now;
    bit                loaded     [SLOTS];
    bit                ready      [SLOTS];
    logic [TIME_W-1:0] arrival    [SLOTS];
    logic [TIME_W-1:0] remaining  [SLOTS];
    logic [TIME_W-1:0] last_aging [SLOTS];
    logic [PRI_W-1:0]  prio       [SLOTS];
    tick_report_t      expected_ticks [$];
    int                mismatches;

    function new();
      interval   = AGING_RESET;
      now        = '0;
      mismatches = 0;
      foreach (loaded[s]) begin
        loaded[s]     = 1'b0;
        ready[s]      = 1'b0;
        arrival[s]    = '0;
        remaining[s]  = '0;
        last_aging[s] = '0;
        prio[s]       = '0;
      end
    endfunction

    // Applies one accepted input transfer and queues the report of a tick.
    function void accept_item(sched_item_t it);
      tick_report_t      rep;
      logic [TIME_W-1:0] waited;
      bit                found;
      int                best;
      case (it.kind)
        KIND_CLEAR: begin
          foreach (loaded[s]) begin
            loaded[s] = 1'b0;
            ready[s]  = 1'b0;
          end
          now = '0;
        end
        KIND_LOAD: begin
          if (int'(it.slot) < SLOTS) begin
            arrival[it.slot]    = it.arrival;
            remaining[it.slot]  = it.burst;
            prio[it.slot]       = it.prio;
            last_aging[it.slot] = it.arrival;
            loaded[it.slot]     = 1'b1;
            ready[it.slot]      = 1'b0;
          end
        end
        KIND_TICK: begin
          found = 1'b0;
          best  = 0;
          foreach (loaded[s]) begin
            if (loaded[s] && !ready[s] && remaining[s] != '0 && arrival[s] == now)
              ready[s] = 1'b1;
          end
          foreach (ready[s]) begin
            waited = now - last_aging[s];
            if (ready[s] && waited >= interval) begin
              prio[s]       = (prio[s] > PRI_FLOOR) ? prio[s] - 8'd1 : PRI_FLOOR;
              last_aging[s] = now;
            end
          end
          foreach (ready[s]) begin
            if (ready[s] && (!found || prio[s] < prio[best])) begin
              found = 1'b1;
              best  = s;
            end
          end
          rep = '0;
          if (found) begin
            remaining[best] = remaining[best] - 16'd1;
            rep.ran      = 1'b1;
            rep.run_slot = SLOT_W'(best);
            if (remaining[best] == '0) begin
              rep.slot_finished = 1'b1;
              ready[best]       = 1'b0;
            end
          end
          rep.tick_time = now;
          rep.all_done  = 1'b1;
          foreach (loaded[s]) begin
            if (loaded[s] && remaining[s] != '0)
              rep.all_done = 1'b0;
          end
          expected_ticks = {expected_ticks, rep};
          if (now != TIME_MAX)
            now = now + 16'd1;
        end
        default: ;
      endcase
    endfunction

    function void check_tick(tick_report_t got);
      tick_report_t want;
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected report ran=%0d slot=%0d time=%0d fin=%0d done=%0d",
                   got.ran, got.run_slot, got.tick_time, got.slot_finished, got.all_done);
        return;
      end
      want = expected_ticks.pop_front();
      if (got.ran !== want.ran || got.run_slot !== want.run_slot ||
          got.tick_time !== want.tick_time || got.slot_finished !== want.slot_finished ||
          got.all_done !== want.all_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected ran=%0d slot=%0d time=%0d fin=%0d done=%0d, got ran=%0d slot=%0d time=%0d fin=%0d done=%0d",
                   want.ran, want.run_slot, want.tick_time, want.slot_finished,
                   want.all_done, got.ran, got.run_slot, got.tick_time,
                   got.slot_finished, got.all_done);
      end
    endfunction

    function int closing_failures();
      if (expected_ticks.size() != 0) begin
        mismatches++;
        $display("ERROR: %0d tick reports never arrived", expected_ticks.size());
      end
      return mismatches;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;

  pas_in_if  in_ch ();
  pas_out_if out_ch ();

  schedule_checker #(SLOT_COUNT) sched;
  tick_report_t seen;

  // Idle and stall chances in percent, changed only between phases.
  int idle_pct   = 0;
  int stall_pct  = 0;
  int items_sent = 0;

  priority_aging_scheduler_core #(.NUM_SLOTS(SLOT_COUNT)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  function automatic sched_item_t item_of(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                          logic [TIME_W-1:0] arr, logic [TIME_W-1:0] burst,
                                          logic [PRI_W-1:0] pri);
    sched_item_t it;
    it.kind    = kind;
    it.slot    = slot;
    it.arrival = arr;
    it.burst   = burst;
    it.prio    = pri;
    return it;
  endfunction

  // A tick ignores every field but the kind, so the rest carries random bits.
  function automatic sched_item_t tick_item();
    return item_of(KIND_TICK, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                   PRI_W'($urandom));
  endfunction

  // Mostly short bursts so batches finish, with some zero and full-range ones.
  function automatic logic [TIME_W-1:0] pick_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return '0;
    else if (r < 8)
      return TIME_W'($urandom);
    return TIME_W'($urandom_range(1, 6));
  endfunction

  // Half of the priorities crowd near the floor so that ties are common.
  function automatic logic [PRI_W-1:0] pick_prio();
    if ($urandom_range(0, 1) == 0)
      return PRI_W'($urandom_range(0, 3));
    return PRI_W'($urandom);
  endfunction

  // Presents one item, optionally after a random idle burst, and returns at
  // the clock edge where the transfer takes place. Valid stays high on return
  // so that back-to-back items follow without a gap.
  task automatic send_item(input sched_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= it.kind;
    in_ch.slot          <= it.slot;
    in_ch.arrival_time  <= it.arrival;
    in_ch.burst_time    <= it.burst;
    in_ch.base_priority <= it.prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sched.accept_item(it);
    if (it.kind != KIND_UNUSED)
      items_sent++;
  endtask

  // Holds the input side off until every owed report has come, then lets the
  // block settle so that it is idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sched.expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The register is only written while the block is idle, after drain().
  task automatic write_interval(input logic [TIME_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    sched.interval  = value;
  endtask

  // One well-formed batch of work: an optional clear, a few loads that arrive
  // within a handful of ticks, then enough ticks to run them out. Now and then
  // a load lands mid-run to force preemption, and a little noise is mixed in.
  task automatic run_batch();
    int                jobs;
    int                budget;
    int                ticks;
    int                j;
    int                r;
    logic [TIME_W-1:0] burst;
    jobs   = $urandom_range(1, 6);
    budget = 0;
    if ($urandom_range(0, 9) == 0)
      drain();
    if ($urandom_range(0, 2) == 0)
      send_item(item_of(KIND_CLEAR, SLOT_W'($urandom), TIME_W'($urandom),
                        TIME_W'($urandom), PRI_W'($urandom)));
    for (j = 0; j < jobs; j++) begin
      burst   = pick_burst();
      budget += (burst > 16'd12) ? 12 : int'(burst);
      send_item(item_of(KIND_LOAD, SLOT_W'($urandom),
                        sched.now + TIME_W'($urandom_range(0, 6)), burst, pick_prio()));
    end
    ticks = budget + int'($urandom_range(2, 8));
    if (ticks > 60)
      ticks = 60;
    for (j = 0; j < ticks; j++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(item_of(KIND_LOAD, SLOT_W'($urandom),
                          sched.now + TIME_W'($urandom_range(1, 4)), pick_burst(),
                          pick_prio()));
      end else if (r < 12) begin
        case ($urandom_range(0, 3))
          0: send_item(item_of(KIND_UNUSED, SLOT_W'($urandom), TIME_W'($urandom),
                               TIME_W'($urandom), PRI_W'($urandom)));
          1: send_item(item_of(KIND_LOAD, SLOT_W'($urandom), TIME_W'($urandom),
                               TIME_W'($urandom), PRI_W'($urandom)));
          // An arrival that already lies in the past; the slot never runs.
          2: send_item(item_of(KIND_LOAD, SLOT_W'($urandom), sched.now - 16'd1,
                               pick_burst(), pick_prio()));
          default: send_item(item_of(KIND_CLEAR, SLOT_W'($urandom), TIME_W'($urandom),
                                     TIME_W'($urandom), PRI_W'($urandom)));
        endcase
      end
      send_item(tick_item());
    end
  endtask

  // Result side: ready drops in random bursts while the phase asks for stalls.
  initial begin : result_sink
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Every result transfer is checked against the oldest owed report.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen.ran           = out_ch.ran;
      seen.run_slot      = out_ch.run_slot;
      seen.tick_time     = out_ch.tick_time;
      seen.slot_finished = out_ch.slot_finished;
      seen.all_done      = out_ch.all_done;
      sched.check_tick(seen);
    end
  end

  // The watchdog ends a run in which no transfer happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int                phase;
    int                j;
    logic [TIME_W-1:0] value;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_CLEAR;
    in_ch.slot          <= '0;
    in_ch.arrival_time  <= '0;
    in_ch.burst_time    <= '0;
    in_ch.base_priority <= '0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    sched = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the aging interval at its reset value of five.
    // A tick with nothing loaded runs nothing and reports all done.
    send_item(tick_item());
    // The unused kind with every field bit set must leave no trace.
    send_item(item_of(KIND_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_item(item_of(KIND_CLEAR, 4'h0, 16'h0000, 16'h0000, 8'h00));
    // Priority zero in the top slot against priority one in slot zero.
    send_item(item_of(KIND_LOAD, 4'd15, 16'd1, 16'd2, 8'd0));
    send_item(item_of(KIND_LOAD, 4'd0, 16'd1, 16'd2, 8'd1));
    // A zero burst never becomes ready and counts as finished work.
    send_item(item_of(KIND_LOAD, 4'd3, 16'd0, 16'd0, 8'd7));
    send_item(item_of(KIND_LOAD, 4'd7, 16'd0, 16'd3, 8'd255));
    send_item(tick_item());
    // Arrival zero is already in the past here, so slot nine never runs.
    send_item(item_of(KIND_LOAD, 4'd9, 16'd0, 16'd4, 8'd0));
    // Slot twelve ties with slot zero at priority one; the lower index wins.
    send_item(item_of(KIND_LOAD, 4'd12, 16'd2, 16'd1, 8'd1));
    // Largest field values: an arrival far beyond reach keeps all_done low.
    send_item(item_of(KIND_LOAD, 4'd5, 16'hFFFF, 16'hFFFF, 8'hFF));
    for (j = 0; j < 12; j++)
      send_item(tick_item());

    // Interval zero: every ready slot ages on every tick, including the tick
    // it arrives on. Slot zero runs first, slot one arrives later with
    // priority zero and takes over, and slot two waits behind both of them.
    drain();
    write_interval(16'd0);
    send_item(item_of(KIND_CLEAR, 4'h0, 16'h0000, 16'h0000, 8'h00));
    send_item(item_of(KIND_LOAD, 4'd0, 16'd0, 16'd30, 8'd200));
    send_item(item_of(KIND_LOAD, 4'd1, 16'd5, 16'd3, 8'd0));
    send_item(item_of(KIND_LOAD, 4'd2, 16'd10, 16'd20, 8'd255));
    for (j = 0; j < ZERO_TICKS; j++)
      send_item(tick_item());
    send_item(item_of(KIND_CLEAR, 4'h0, 16'h0000, 16'h0000, 8'h00));

    // Random phases, each with its own aging interval and idling mix.
    drain();
    items_sent = 0;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: value = 16'd0;
        1: value = 16'd1;
        2: value = 16'hFFFF;
        3: value = 16'd2;
        4: value = TIME_W'($urandom_range(0, 8));
        5: value = AGING_RESET;
        6: value = TIME_W'($urandom);
        default: value = TIME_W'($urandom_range(1, 4));
      endcase
      drain();
      write_interval(value);
      if (phase == PHASE_COUNT - 1) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      while (items_sent < (phase + 1) * PHASE_ITEMS)
        run_batch();
    end

    drain();
    if (sched.closing_failures() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
